### rtl/core/ppo_pkg.sv
// Package for the point projection occlusion plotter.
// Holds the beat types, register indexes and pipeline constants.
// Depends on nothing; every rtl/core file imports it.
package ppo_pkg;

  localparam int QW      = 31;
  localparam int DIV_LAT = QW + 2;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_PLOT = 1'b1;

  localparam logic [2:0] REG_FOCAL   = 3'd0;
  localparam logic [2:0] REG_FOCAL_A = 3'd1;
  localparam logic [2:0] REG_OFF_X   = 3'd2;
  localparam logic [2:0] REG_OFF_Y   = 3'd3;
  localparam logic [2:0] REG_MIN_COL = 3'd4;
  localparam logic [2:0] REG_MAX_COL = 3'd5;
  localparam logic [2:0] REG_MIN_ROW = 3'd6;
  localparam logic [2:0] REG_MAX_ROW = 3'd7;

  typedef struct packed {
    logic               func;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [7:0]         paint;
    logic               last_vertex;
    logic [8:0]         column;
    logic signed [31:0] col_depth;
    logic [9:0]         col_top;
    logic [9:0]         col_bottom;
  } ppo_in_t;

  typedef struct packed {
    logic        pixel_write;
    logic [8:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [19:0] pixel_addr;
    logic [7:0]  pixel_color;
    logic        last;
  } ppo_out_t;

  typedef struct packed {
    logic               func;
    logic               keep;
    logic               last;
    logic [7:0]         paint;
    logic signed [31:0] vert_z;
    logic [8:0]         column;
    logic signed [31:0] col_depth;
    logic [9:0]         col_top;
    logic [9:0]         col_bottom;
  } ppo_side_t;

endpackage

### rtl/core/ppo_mul.sv
// One registered 16.16 multiply of a coordinate by a focal length.
// Depends on ppo_pkg.
module ppo_mul (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] coord_i,
  input  logic [30:0]        focal_i,
  output logic signed [31:0] prod_o
);
  import ppo_pkg::*;

  logic signed [63:0] full;
  logic signed [31:0] prod_q;

  assign full = coord_i * $signed({1'b0, focal_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= full[47:16];
    end
  end

  assign prod_o = prod_q;
endmodule

### rtl/core/ppo_div.sv
// Pipelined restoring divider: (prod * 65536) / z, truncated toward zero.
// One quotient bit per stage; depends on ppo_pkg for the stage count.
module ppo_div (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] prod_i,
  input  logic signed [31:0] z_i,
  output logic signed [31:0] quo_o
);
  import ppo_pkg::*;

  logic [31:0]   rem_q [QW+1];
  logic [QW-1:0] dvd_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic          neg_q [QW+1];
  logic [31:0]   zd_q  [QW+1];
  logic [32:0]   mag;
  logic [31:0]   out_q;

  assign mag = prod_i[31] ? (33'd0 - {prod_i[31], prod_i}) : {1'b0, prod_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {14'd0, mag[32:15]};
      dvd_q[0] <= {mag[14:0], 16'd0};
      quo_q[0] <= '0;
      neg_q[0] <= prod_i[31];
      zd_q[0]  <= z_i;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [32:0] t;
    logic [32:0] diff;
    logic        ge;
    assign t    = {rem_q[k-1], dvd_q[k-1][QW-1]};
    assign diff = t - {1'b0, zd_q[k-1]};
    assign ge   = (t >= {1'b0, zd_q[k-1]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[31:0] : t[31:0];
        dvd_q[k] <= {dvd_q[k-1][QW-2:0], 1'b0};
        quo_q[k] <= {quo_q[k-1][QW-2:0], ge};
        neg_q[k] <= neg_q[k-1];
        zd_q[k]  <= zd_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= neg_q[QW] ? (32'd0 - {1'b0, quo_q[QW]}) : {1'b0, quo_q[QW]};
    end
  end

  assign quo_o = $signed(out_q);
endmodule

### rtl/core/point_projection_occlusion_plot.sv
// Top level of the point projection occlusion plotter.
// Instantiates ppo_mul and ppo_div, holds the column store; uses ppo_pkg.
//
//   channel | signals                      | direction
//   in      | in_valid_i in_stall_o in_data_i  | beat into the block
//   out     | out_valid_o out_stall_i out_data_o | beat out of the block
//   cfg     | cfg_we_i cfg_idx_i cfg_data_i      | register write
//
// One beat per cycle while the output is not stalled; the divider has 31 steps.
// Reset clears valid bits and loads the register reset values; the column
// store is not cleared. The whole pipeline holds while the output is stalled
// and full; a beat enters whenever the output register is empty or taken.
module point_projection_occlusion_plot #(
  parameter int COLUMNS      = 512,
  parameter int SCREEN_WIDTH = 320
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ppo_pkg::ppo_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ppo_pkg::ppo_out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [30:0]      cfg_data_i
);
  import ppo_pkg::*;

  localparam int CW = $clog2(COLUMNS);

  function automatic logic [CW-1:0] col_mod(input logic [8:0] v);
    logic [12:0] r;
    r = {4'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (r >= 13'(COLUMNS)) begin
        r = r - 13'(COLUMNS);
      end
    end
    return r[CW-1:0];
  endfunction

  logic [30:0] focal_q, focal_a_q, off_x_q, off_y_q;
  logic [8:0]  min_col_q, max_col_q;
  logic [9:0]  min_row_q, max_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q   <= '0;
      focal_a_q <= '0;
      off_x_q   <= '0;
      off_y_q   <= '0;
      min_col_q <= '0;
      max_col_q <= 9'd319;
      min_row_q <= '0;
      max_row_q <= 10'd199;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FOCAL:   focal_q   <= cfg_data_i;
        REG_FOCAL_A: focal_a_q <= cfg_data_i;
        REG_OFF_X:   off_x_q   <= cfg_data_i;
        REG_OFF_Y:   off_y_q   <= cfg_data_i;
        REG_MIN_COL: min_col_q <= cfg_data_i[8:0];
        REG_MAX_COL: max_col_q <= cfg_data_i[8:0];
        REG_MIN_ROW: min_row_q <= cfg_data_i[9:0];
        REG_MAX_ROW: max_row_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic vo_q;
  assign adv        = !vo_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Input register.
  ppo_in_t in_q;
  logic    v0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q <= in_data_i;
    end
  end

  // Multiply stage.
  ppo_side_t side0, side1_q;
  logic      v1_q;
  logic signed [31:0] prod_x, prod_y;

  always_comb begin
    side0.func       = in_q.func;
    side0.keep       = (in_q.paint != 8'd0) && (in_q.vert_z > 32'sd65536);
    side0.last       = in_q.last_vertex;
    side0.paint      = in_q.paint;
    side0.vert_z     = in_q.vert_z;
    side0.column     = in_q.column;
    side0.col_depth  = in_q.col_depth;
    side0.col_top    = in_q.col_top;
    side0.col_bottom = in_q.col_bottom;
  end

  ppo_mul u_mul_x (.clk_i, .en_i(adv), .coord_i(in_q.vert_x), .focal_i(focal_q),
                   .prod_o(prod_x));
  ppo_mul u_mul_y (.clk_i, .en_i(adv), .coord_i(in_q.vert_y), .focal_i(focal_a_q),
                   .prod_o(prod_y));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= v0_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side1_q <= side0;
    end
  end

  // Divide stages with the side line running alongside.
  logic signed [31:0] quo_x, quo_y;
  ppo_side_t sd_q [DIV_LAT];
  logic [DIV_LAT-1:0] vd_q;

  ppo_div u_div_x (.clk_i, .en_i(adv), .prod_i(prod_x), .z_i(side1_q.vert_z),
                   .quo_o(quo_x));
  ppo_div u_div_y (.clk_i, .en_i(adv), .prod_i(prod_y), .z_i(side1_q.vert_z),
                   .quo_o(quo_y));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= '0;
    end else if (adv) begin
      vd_q <= {vd_q[DIV_LAT-2:0], v1_q};
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q[0] <= side1_q;
      for (int k = 1; k < DIV_LAT; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  // Offset, rounding and column window.
  logic [31:0] sum_x, sum_y, rnd_x, rnd_y;
  logic signed [15:0] px, py;
  logic col_ok;
  assign sum_x = quo_x + {1'b0, off_x_q};
  assign sum_y = quo_y + {1'b0, off_y_q};
  assign rnd_x = sum_x + 32'h8000;
  assign rnd_y = sum_y + 32'h8000;
  assign px    = $signed(rnd_x[31:16]);
  assign py    = $signed(rnd_y[31:16]);
  assign col_ok = sd_q[DIV_LAT-1].keep
                  && (px >= $signed({7'd0, min_col_q}))
                  && (px <= $signed({7'd0, max_col_q}));

  ppo_side_t sp_q;
  logic signed [15:0] px_q, py_q;
  logic colok_q, vp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (adv) begin
      vp_q <= vd_q[DIV_LAT-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sp_q    <= sd_q[DIV_LAT-1];
      px_q    <= px;
      py_q    <= py;
      colok_q <= col_ok;
    end
  end

  // Column store access: loads write, plots read, in beat order.
  logic [51:0] mem [COLUMNS];
  logic [51:0] rd_q;
  logic [CW-1:0] maddr;
  ppo_side_t sm_q;
  logic signed [15:0] pxm_q, pym_q;
  logic colokm_q, vm_q;

  assign maddr = (sp_q.func == FUNC_LOAD) ? col_mod(sp_q.column) : col_mod(px_q[8:0]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (vp_q && sp_q.func == FUNC_LOAD) begin
        mem[maddr] <= {sp_q.col_depth, sp_q.col_top, sp_q.col_bottom};
      end
      rd_q <= mem[maddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (adv) begin
      vm_q <= vp_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sm_q     <= sp_q;
      pxm_q    <= px_q;
      pym_q    <= py_q;
      colokm_q <= colok_q;
    end
  end

  // Depth, row span and address.
  logic signed [31:0] depth;
  logic signed [15:0] top, bot;
  logic hit;
  logic [19:0] addr;
  ppo_out_t res, out_q;

  assign depth = $signed(rd_q[51:20]);
  assign top   = $signed({6'd0, rd_q[19:10]});
  assign bot   = $signed({6'd0, rd_q[9:0]});
  assign hit   = (sm_q.func == FUNC_PLOT) && colokm_q
                 && (sm_q.vert_z < depth)
                 && (pym_q >= $signed({6'd0, min_row_q}))
                 && (pym_q <= $signed({6'd0, max_row_q}))
                 && (pym_q >= top) && (pym_q <= bot);
  assign addr  = 20'(pym_q[9:0]) * 20'(SCREEN_WIDTH) + 20'(pxm_q[8:0]);

  always_comb begin
    res = '0;
    res.last = (sm_q.func == FUNC_PLOT) && sm_q.last;
    if (hit) begin
      res.pixel_write = 1'b1;
      res.pixel_x     = pxm_q[8:0];
      res.pixel_y     = pym_q[9:0];
      res.pixel_addr  = addr;
      res.pixel_color = sm_q.paint;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (adv) begin
      vo_q <= vm_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled output beat");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.pixel_write) |->
      (out_data_o.pixel_addr == 20'd0 && out_data_o.pixel_color == 8'd0))
    else $error("dropped beat carries pixel data");

  a_write_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.pixel_write) |-> (out_data_o.pixel_color != 8'd0))
    else $error("pixel write with transparent color");

endmodule
